[hw/rtl/cqs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the circular queue with search.
// No dependencies; imported by every module of the block.
package cqs_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FN_ENQ    = 2'd0,
    FN_DEQ    = 2'd1,
    FN_SEARCH = 2'd2,
    FN_NONE   = 2'd3
  } cqs_func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NOTFOUND  = 2'd3
  } cqs_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN,
    S_RESP
  } cqs_state_t;

  typedef struct packed {
    cqs_status_t        status;
    logic [POS_W-1:0]   pos;
    logic signed [WORD_W-1:0] data;
  } cqs_resp_t;

endpackage

[hw/rtl/cqs_ram.sv]
`timescale 1ns / 1ps
// Entry storage: one write port, one read port with registered read data.
// Depends on cqs_pkg for the word width.
module cqs_ram
  import cqs_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [WORD_W-1:0] wr_data,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [WORD_W-1:0] rd_data
);

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/cqs_seq.sv]
`timescale 1ns / 1ps
// Sequencer: ring pointers, fill count, and the one-entry-per-cycle search
// that drives a single shared equality compare. Depends on cqs_pkg, cqs_ram.
module cqs_seq
  import cqs_pkg::*;
#(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3,
  parameter int unsigned CW    = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     resp_valid,
  input  logic                     resp_take,
  output cqs_resp_t                resp
);

  cqs_state_t state_r, state_nxt;

  logic [AW-1:0] head_r, tail_r, slot_r;
  logic [CW-1:0] count_r, k_r;
  logic signed [WORD_W-1:0] key_r;
  cqs_resp_t     resp_r;

  logic                     accept;
  logic                     wr_en;
  logic [AW-1:0]            rd_addr;
  logic signed [WORD_W-1:0] rd_data;
  logic                     is_empty, is_full;
  logic                     hit, last;
  logic [CW-1:0]            k_plus;
  logic [CW+POS_W-1:0]      k_ext;
  cqs_func_t                func;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  assign func     = cqs_func_t'(in_func);
  assign accept   = in_valid && in_ready;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(DEPTH));
  assign wr_en    = accept && (func == FN_ENQ) && !is_full;
  assign rd_addr  = (state_r == S_SCAN) ? slot_r : head_r;

  // shared compare unit
  assign hit    = (rd_data == key_r);
  assign k_plus = k_r + 1'b1;
  assign last   = (k_plus == count_r);
  assign k_ext  = {{POS_W{1'b0}}, k_plus};

  cqs_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (in_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (func == FN_DEQ && !is_empty) state_nxt = S_DEQ;
          else if (func == FN_SEARCH && !is_empty) state_nxt = S_SCAN;
          else state_nxt = S_RESP;
        end
      end
      S_DEQ:  state_nxt = S_RESP;
      S_SCAN: begin
        if (hit || last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (resp_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    resp_valid = (state_r == S_RESP);
    resp       = resp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        unique case (func)
          FN_ENQ: begin
            if (!is_full) begin
              tail_r  <= next_slot(tail_r);
              count_r <= count_r + 1'b1;
            end
          end
          FN_DEQ: begin
            if (!is_empty) begin
              head_r  <= next_slot(head_r);
              count_r <= count_r - 1'b1;
            end
          end
          FN_SEARCH, FN_NONE: ;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        key_r  <= in_value;
        slot_r <= next_slot(head_r);
        k_r    <= '0;
        resp_r.pos    <= '0;
        resp_r.data   <= '0;
        if (func == FN_ENQ && is_full) begin
          resp_r.status <= ST_OVERFLOW;
        end else if ((func == FN_DEQ || func == FN_SEARCH) && is_empty) begin
          resp_r.status <= ST_UNDERFLOW;
        end else begin
          resp_r.status <= ST_OK;
        end
      end
      S_DEQ: resp_r.data <= rd_data;
      S_SCAN: begin
        slot_r <= next_slot(slot_r);
        k_r    <= k_plus;
        if (hit) begin
          resp_r.pos <= k_ext[POS_W-1:0];
        end else if (last) begin
          resp_r.status <= ST_NOTFOUND;
        end
      end
      S_RESP: ;
      default: ;
    endcase
  end

endmodule

[hw/rtl/circular_queue_with_search_top.sv]
`timescale 1ns / 1ps
// Top level of the circular queue with search: stream ports and output
// register. Depends on cqs_pkg and cqs_seq (which holds cqs_ram).
//
//  channel  | dir | tdata                      | tuser
//  ---------+-----+----------------------------+-------------
//  in_      | in  | value[31:0]                | func[1:0]
//  out_     | out | data_out[31:0], position   | status[1:0]
//
// Enqueue, underflow/overflow and the unused selector go from accept straight
// to the response step and the output register; a dequeue first passes a
// read step (registered RAM read); a search first passes the scan step,
// comparing k entries (up to the fill count), one entry per cycle from the
// RAM read port. in_tready is low while an item is in work. A result waiting
// on out_tready holds the sequencer in its response step. rst_n is
// synchronous; it empties the queue, stored words are not cleared.
module circular_queue_with_search_top
  import cqs_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[31:0]
  input  logic [FUNC_W-1:0]      in_tuser,   // func[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data_out[31:0], position[35:32], zeros
  output logic [STATUS_W-1:0]    out_tuser   // status[1:0]
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                   resp_valid, resp_take;
  cqs_resp_t              resp;
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [STATUS_W-1:0]    out_tuser_r;

  cqs_seq #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_func    (in_tuser),
    .in_value   (in_tdata),
    .resp_valid (resp_valid),
    .resp_take  (resp_take),
    .resp       (resp)
  );

  assign resp_take = resp_valid && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (resp_take) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_take) begin
      out_tdata_r <= {{(OUT_TDATA_W - WORD_W - POS_W){1'b0}}, resp.pos, resp.data};
      out_tuser_r <= resp.status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
